FILE: hdl/rsd_pkg.sv
`timescale 1ns / 1ps

package rsd_pkg;

    // Width of the Euclid arithmetic (4 to 32)
    localparam int VALUE_BITS  = 16;
    // Width of every external value field
    localparam int FIELD_BITS  = 16;
    // Results per item before the item is cut off
    localparam int MAX_RESULTS = 25;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int RND_BITS = $clog2(MAX_RESULTS + 1);
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [FIELD_BITS-1:0] t_field;

    // One rectangle waiting for the back end
    typedef struct packed {
        t_val dividend;
        t_val divisor;
    } t_item;

    // Queue to back-end handshake
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

FILE: hdl/rsd_front.sv
`timescale 1ns / 1ps

module rsd_front import rsd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_field i_rect_width,
    input  t_field i_rect_height,
    output logic   o_push_valid,
    input  logic   i_push_ready,
    output t_item  o_push_item
);

    logic  r_valid;
    t_item r_item;
    t_val  w_width;
    t_val  w_height;
    logic  w_in_fire;

    // mask / extend to the arithmetic width
    assign w_width   = t_val'(i_rect_width);
    assign w_height  = t_val'(i_rect_height);
    assign o_in_ready = !r_valid || i_push_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            // zero height: word is taken and dropped, no rounds to run
            if (w_in_fire && (w_height != '0)) begin
                r_valid         <= 1'b1;
                r_item.dividend <= w_width;
                r_item.divisor  <= w_height;
            end else if (i_push_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/rsd_queue.sv
`timescale 1ns / 1ps

module rsd_queue import rsd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_item  i_push_item,
    output t_q_out o_q,
    input  logic   i_pop
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_push_ready = (r_count != QCNT_BITS'(QUEUE_DEPTH));
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_q.valid    = (r_count != '0);
    assign o_q.item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr_ptr] <= i_push_item;
                r_wr_ptr <= (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/rsd_back.sv
`timescale 1ns / 1ps

module rsd_back import rsd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_out i_q,
    output logic   o_pop,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_field o_square_side,
    output t_field o_square_count,
    output logic   o_last_term
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state              r_state;
    t_val                r_b;       // divisor, the square side
    t_val                r_rem;     // partial remainder
    t_val                r_quo;     // dividend shifting out, quotient shifting in
    logic [CNT_BITS-1:0] r_cnt;
    logic [RND_BITS-1:0] r_rounds;
    logic                r_out_valid;
    t_field              r_out_side;
    t_field              r_out_count;
    logic                r_out_last;

    logic [VALUE_BITS:0]   w_trial;
    logic [VALUE_BITS:0]   w_diff;
    logic                  w_borrow;
    logic [RND_BITS-1:0]   n_rounds;
    logic                  w_out_free;
    logic                  w_done;
    logic                  w_emit;

    // one restoring step: shift in next dividend bit, try subtract
    assign w_trial  = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_diff   = w_trial - {1'b0, r_b};
    assign w_borrow = w_diff[VALUE_BITS];

    assign n_rounds   = r_rounds + 1'b1;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_done     = (r_rem == '0) || (n_rounds == RND_BITS'(MAX_RESULTS));
    assign w_emit     = (r_state == ST_EMIT) && w_out_free;

    assign o_pop          = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_square_side  = r_out_side;
    assign o_square_count = r_out_count;
    assign o_last_term    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q.valid) begin
                        r_b      <= i_q.item.divisor;
                        r_quo    <= i_q.item.dividend;
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_rounds <= '0;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_borrow ? w_trial[VALUE_BITS-1:0] : w_diff[VALUE_BITS-1:0];
                    r_quo <= {r_quo[VALUE_BITS-2:0], !w_borrow};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(VALUE_BITS - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_side  <= t_field'(r_b);
                        r_out_count <= t_field'(r_quo);
                        r_out_last  <= (r_rem == '0);
                        r_rounds    <= n_rounds;
                        if (w_done) begin
                            r_state <= ST_IDLE;
                        end else begin
                            // next round on (divisor, remainder)
                            r_quo   <= r_b;
                            r_b     <= r_rem;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_b != '0))
        else $error("divide by zero in round");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_EMIT) |-> (r_rem < r_b))
        else $error("partial remainder not below divisor");

    a_round_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_rounds < RND_BITS'(MAX_RESULTS)))
        else $error("round count past limit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free && r_rem == '0) |=> (r_state == ST_IDLE))
        else $error("rounds continue after zero remainder");
`endif

endmodule

FILE: hdl/rectangle_square_decomposition.sv
`timescale 1ns / 1ps

// Euclid / continued-fraction engine. Each input word (rect_width, rect_height)
// yields one output word per Euclid round: square_side is the current divisor,
// square_count the quotient, and last_term marks the round whose remainder is
// zero. A zero height yields no output words; a zero width yields a single word
// with count 0. Results stop after MAX_RESULTS rounds (reachable only with
// VALUE_BITS above 16), and then the final word has last_term clear.
// The front stage takes a word per cycle into a two-entry queue unless a full
// queue holds it back. The back end works on one rectangle at a time: it pulls
// the rectangle from the queue, then for each round runs the one-bit-per-cycle
// restoring divider and hands the result to the output register. The output
// register lets the next division run while a result waits; a held result
// stalls only the following hand-off.

module rectangle_square_decomposition import rsd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_field i_rect_width,
    input  t_field i_rect_height,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_field o_square_side,
    output t_field o_square_count,
    output logic   o_last_term
);

    logic   w_push_valid;
    logic   w_push_ready;
    t_item  w_push_item;
    t_q_out w_q;
    logic   w_pop;

    // front: take words, drop zero-height rectangles
    rsd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_push_item   (w_push_item)
    );

    // decouples front from the long-running back end
    rsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_item  (w_push_item),
        .o_q          (w_q),
        .i_pop        (w_pop)
    );

    // back: Euclid rounds on a shared restoring divider
    rsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (w_q),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_square_side  (o_square_side),
        .o_square_count (o_square_count),
        .o_last_term    (o_last_term)
    );

endmodule
